FILE: rtl/cbb_pkg.sv
// Shared types and constants for the bounding-box centering block.
// Used by the image RAM and by the top level; depends on nothing else.
`default_nettype none

package cbb_pkg;

   localparam int PIXEL_W = 8;
   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd25;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

endpackage

`default_nettype wire

FILE: rtl/center_by_bounding_box.sv
// Bounding-box centering: stores one square image and streams it back centered.
// A read beat's result passes the RAM read register and then the output register;
// the RAM reads at the accept edge and the output register loads once it is free.
// Throughput: one beat per cycle, reads and writes alike, as each needs a single
// RAM access; any beat is held while a read result waits behind a stalled output.
// Reset clears positions, box and threshold (25); the pixel store is not cleared.
`default_nettype none

module center_by_bounding_box #(
   parameter int IMAGE_SIDE = 28
) (
   input  wire                          clock,
   input  wire                          reset,
   // Input stream.
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [7:0]                   req_tdata,   // [7:0] pixel_in
   input  wire                          req_tuser,   // [0] operation
   // Result stream.
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] pixel_out
   output logic                         rsp_tlast,   // last_pixel
   // Threshold register.
   input  wire                          csr_wr_en,
   input  wire  [7:0]                   csr_wr_data
);

   localparam int PIXELS = IMAGE_SIDE * IMAGE_SIDE;
   localparam int CW     = $clog2(IMAGE_SIDE + 1);
   localparam int AW     = $clog2(PIXELS);
   localparam logic [CW-1:0] SideC    = CW'(IMAGE_SIDE);
   localparam logic [CW-1:0] SideLast = CW'(IMAGE_SIDE - 1);
   localparam logic [AW-1:0] PosLast  = AW'(PIXELS - 1);

   logic [7:0]    thresh_ff;
   logic [AW-1:0] wr_pos_ff, wr_pos_in, rd_pos_ff, rd_pos_in;
   logic [CW-1:0] wx_ff, wx_in, wy_ff, wy_in, rx_ff, rx_in, ry_ff, ry_in;
   logic [CW-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic [CW-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic          pend_ff, pend_in, zero_ff, zero_in, plast_ff, plast_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   logic          accept, wr_acc, rd_acc, rsp_load;
   logic          new_image, ink, degenerate, in_box;
   logic [CW-1:0] base_min_x, base_min_y, base_max_x, base_max_y;
   logic [CW-1:0] box_w, box_h, off_x, off_y, src_x, src_y;
   logic [AW-1:0] rd_addr;
   logic [7:0]    ram_q;

   assign rsp_load   = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign wr_acc     = accept && (req_tuser == cbb_pkg::OP_WRITE);
   assign rd_acc     = accept && (req_tuser == cbb_pkg::OP_READ);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A write lands in the RAM at its accept edge, so a read accepted on the
   // next cycle already sees it; the two never meet in one cycle.
   cbb_image_ram #(
      .DEPTH (PIXELS),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_acc),
      .wr_addr    (wr_pos_ff),
      .wr_data    (req_tdata),
      .rd_en      (rd_acc),
      .rd_addr    (rd_addr),
      .rd_data_ff (ram_q)
   );

   // Box update for a write; the first pixel of an image restarts the box.
   always_comb begin
      new_image  = (wr_pos_ff == '0);
      base_min_x = new_image ? SideC : min_x_ff;
      base_min_y = new_image ? SideC : min_y_ff;
      base_max_x = new_image ? '0 : max_x_ff;
      base_max_y = new_image ? '0 : max_y_ff;
      ink        = req_tdata > thresh_ff;
   end

   // Source address for a read, taken from the box as it stands now.
   always_comb begin
      degenerate = (min_x_ff >= max_x_ff) || (min_y_ff >= max_y_ff);
      box_w      = max_x_ff - min_x_ff + CW'(1);
      box_h      = max_y_ff - min_y_ff + CW'(1);
      off_x      = (SideC - box_w) >> 1;
      off_y      = (SideC - box_h) >> 1;
      in_box     = (rx_ff >= off_x) && (rx_ff < off_x + box_w)
                && (ry_ff >= off_y) && (ry_ff < off_y + box_h);
      src_x      = rx_ff - off_x + min_x_ff;
      src_y      = ry_ff - off_y + min_y_ff;
      if (degenerate) begin
         rd_addr = rd_pos_ff;
      end else begin
         rd_addr = AW'(AW'(src_y) * AW'(IMAGE_SIDE)) + AW'(src_x);
      end
   end

   always_comb begin
      wr_pos_in    = wr_pos_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      rd_pos_in    = rd_pos_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      min_x_in     = min_x_ff;
      min_y_in     = min_y_ff;
      max_x_in     = max_x_ff;
      max_y_in     = max_y_ff;
      pend_in      = pend_ff;
      zero_in      = zero_ff;
      plast_in     = plast_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = zero_ff ? 8'd0 : ram_q;
         rsp_last_in  = plast_ff;
         pend_in      = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_acc) begin
         min_x_in = (ink && wx_ff < base_min_x) ? wx_ff : base_min_x;
         min_y_in = (ink && wy_ff < base_min_y) ? wy_ff : base_min_y;
         max_x_in = (ink && wx_ff > base_max_x) ? wx_ff : base_max_x;
         max_y_in = (ink && wy_ff > base_max_y) ? wy_ff : base_max_y;
         if (new_image) begin
            rd_pos_in = '0;
            rx_in     = '0;
            ry_in     = '0;
         end
         if (wr_pos_ff == PosLast) begin
            wr_pos_in = '0;
            wx_in     = '0;
            wy_in     = '0;
         end else begin
            wr_pos_in = wr_pos_ff + AW'(1);
            if (wx_ff == SideLast) begin
               wx_in = '0;
               wy_in = wy_ff + CW'(1);
            end else begin
               wx_in = wx_ff + CW'(1);
            end
         end
      end

      if (rd_acc) begin
         pend_in  = 1'b1;
         zero_in  = !degenerate && !in_box;
         plast_in = (rd_pos_ff == PosLast);
         if (rd_pos_ff == PosLast) begin
            rd_pos_in = '0;
            rx_in     = '0;
            ry_in     = '0;
         end else begin
            rd_pos_in = rd_pos_ff + AW'(1);
            if (rx_ff == SideLast) begin
               rx_in = '0;
               ry_in = ry_ff + CW'(1);
            end else begin
               rx_in = rx_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= cbb_pkg::THRESHOLD_RESET;
         wr_pos_ff    <= '0;
         wx_ff        <= '0;
         wy_ff        <= '0;
         rd_pos_ff    <= '0;
         rx_ff        <= '0;
         ry_ff        <= '0;
         min_x_ff     <= SideC;
         min_y_ff     <= SideC;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         wr_pos_ff    <= wr_pos_in;
         wx_ff        <= wx_in;
         wy_ff        <= wy_in;
         rd_pos_ff    <= rd_pos_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff     <= zero_in;
      plast_ff    <= plast_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: rtl/cbb_image_ram.sv
// Single-port-write, single-port-read synchronous pixel store with registered read data.
// Depends on cbb_pkg for the pixel width.
`default_nettype none

module cbb_image_ram #(
   parameter int DEPTH = 784,
   parameter int AW    = 10
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [AW-1:0]                 wr_addr,
   input  wire  [cbb_pkg::PIXEL_W-1:0]   wr_data,
   input  wire                           rd_en,
   input  wire  [AW-1:0]                 rd_addr,
   output logic [cbb_pkg::PIXEL_W-1:0]   rd_data_ff
);

   logic [cbb_pkg::PIXEL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued, so a stalled result keeps its pixel.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
